FILE: design/psmp_pkg.sv
// Shared types, constants and a helper function for the spatial mode projection block.
`default_nettype none
package psmp_pkg;

	localparam int unsigned MAX_POINTS_DEF = 1048576;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned SUM_W    = 48;
	localparam int unsigned PROD_W   = 32;
	localparam int unsigned OUT_W    = 32;
	localparam int unsigned LANES    = 4;
	localparam int unsigned DIV_W    = 43;
	localparam int unsigned REM_W    = DIV_W + 1;
	localparam int unsigned HEAD_W   = SUM_W - 23;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned CNT_W    = 5;
	localparam int unsigned CMP_W    = 26;

	localparam logic [2:0] CFG_IDX_MODE   = 3'd0;
	localparam logic [2:0] CFG_IDX_NSNAP  = 3'd1;
	localparam logic [2:0] CFG_IDX_EIGEN  = 3'd2;
	localparam logic [2:0] CFG_IDX_NPOINT = 3'd3;

	localparam logic [2:0] MODE_KE_UVW = 3'd0;
	localparam logic [2:0] MODE_P_ONLY = 3'd1;
	localparam logic [2:0] MODE_Q_ALL  = 3'd2;
	localparam logic [2:0] MODE_U      = 3'd3;
	localparam logic [2:0] MODE_V      = 3'd4;
	localparam logic [2:0] MODE_W      = 3'd5;

	localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic acc;
		logic load;
		logic init;
		logic step;
		logic finish;
	} psmp_cmd_t;

	// Lane enables, bit 0 = u, 1 = v, 2 = w, 3 = p.
	function automatic logic [LANES-1:0] lane_sel(input logic [2:0] mode);
		logic [LANES-1:0] sel;
		unique case (mode)
			MODE_KE_UVW: sel = 4'b0111;
			MODE_P_ONLY: sel = 4'b1000;
			MODE_Q_ALL:  sel = 4'b1111;
			MODE_U:      sel = 4'b0001;
			MODE_V:      sel = 4'b0010;
			MODE_W:      sel = 4'b0100;
			default:     sel = 4'b0000;
		endcase
		return sel;
	endfunction

endpackage
`default_nettype wire

FILE: design/psmp_ctrl.sv
// Controller state machine: accumulation, divisor setup, division steps and result hand-off.
`default_nettype none
module psmp_ctrl
	import psmp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  last_snapshot,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	output psmp_cmd_t  cmd
);

	typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_INIT, ST_DIV, ST_FIN} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.acc    = in_valid && (state_q == ST_IDLE);
		cmd.load   = (state_q == ST_LOAD);
		cmd.init   = (state_q == ST_INIT);
		cmd.step   = (state_q == ST_DIV);
		cmd.finish = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result written in the same cycle keeps the output valid.
			if (out_valid_q && out_ready && !cmd.finish)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && last_snapshot)
						state_q <= ST_LOAD;
				end
				ST_LOAD: state_q <= ST_INIT;
				ST_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/psmp_dp.sv
// Datapath: configuration registers, four MAC lanes, four restoring dividers and the output register.
`default_nettype none
module psmp_dp
	import psmp_pkg::*;
#(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire psmp_cmd_t            cmd,
	input  wire logic signed [15:0]   coefficient,
	input  wire logic signed [15:0]   sample_u,
	input  wire logic signed [15:0]   sample_v,
	input  wire logic signed [15:0]   sample_w,
	input  wire logic signed [15:0]   sample_p,
	output logic signed [31:0]        mode_u,
	output logic signed [31:0]        mode_v,
	output logic signed [31:0]        mode_w,
	output logic signed [31:0]        mode_p,
	output logic                      last_point,
	output logic                      overflow
);

	localparam int unsigned PD_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

	logic [2:0]         mode_q;
	logic [10:0]        nsnap_q;
	logic [31:0]        eigen_q;
	logic [20:0]        npoint_q;
	logic [PD_W-1:0]    pd_q;

	logic [SUM_W-1:0]   sum_q  [LANES];
	logic [SUM_W-1:0]   mag_q  [LANES];
	logic               neg_q  [LANES];
	logic               big_q  [LANES];
	logic [REM_W-1:0]   rem_q  [LANES];
	logic [31:0]        dl_q   [LANES];
	logic [31:0]        quo_q  [LANES];
	logic [DIV_W-1:0]   div_q;
	logic [OUT_W-1:0]   res_q  [LANES];
	logic               last_q;
	logic               ovf_q;

	logic signed [SAMPLE_W-1:0] smp [LANES];
	logic [LANES-1:0]           sel;

	assign smp[0] = sample_u;
	assign smp[1] = sample_v;
	assign smp[2] = sample_w;
	assign smp[3] = sample_p;
	assign sel = lane_sel(mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_Q_ALL;
			nsnap_q  <= 11'd1;
			eigen_q  <= 32'd65536;
			npoint_q <= 21'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IDX_MODE:   mode_q   <= cfg_data[2:0];
				CFG_IDX_NSNAP:  nsnap_q  <= cfg_data[10:0];
				CFG_IDX_EIGEN:  eigen_q  <= cfg_data;
				CFG_IDX_NPOINT: npoint_q <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	// Accumulators wrap at 48 bits; they clear once the magnitudes are captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++)
				sum_q[i] <= '0;
		end else begin
			for (int i = 0; i < LANES; i++) begin
				if (cmd.load)
					sum_q[i] <= '0;
				else if (cmd.acc && sel[i])
					sum_q[i] <= sum_q[i] + SUM_W'($signed(
						PROD_W'(coefficient * smp[i])));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q <= DIV_W'(nsnap_q) * DIV_W'(eigen_q);
			for (int i = 0; i < LANES; i++) begin
				neg_q[i] <= sum_q[i][SUM_W-1];
				mag_q[i] <= sum_q[i][SUM_W-1] ? (SUM_W'(0) - sum_q[i]) : sum_q[i];
			end
		end
	end

	// The dividend is mag * 2^9. Its top 25 bits are the starting remainder; a quotient
	// of 2^32 or more is caught up front and saturates.
	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (cmd.init) begin
				big_q[i] <= DIV_W'(mag_q[i][SUM_W-1 -: HEAD_W]) >= div_q;
				rem_q[i] <= REM_W'(mag_q[i][SUM_W-1 -: HEAD_W]);
				dl_q[i]  <= {mag_q[i][22:0], 9'd0};
				quo_q[i] <= '0;
			end else if (cmd.step) begin
				logic [REM_W-1:0] sh;
				logic [REM_W-1:0] trial;
				sh    = {rem_q[i][REM_W-2:0], dl_q[i][31]};
				trial = sh - REM_W'(div_q);
				if (sh >= REM_W'(div_q)) begin
					rem_q[i] <= trial;
					quo_q[i] <= {quo_q[i][30:0], 1'b1};
				end else begin
					rem_q[i] <= sh;
					quo_q[i] <= {quo_q[i][30:0], 1'b0};
				end
				dl_q[i] <= {dl_q[i][30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pd_q <= '0;
		end else if (cmd.finish) begin
			logic [CMP_W-1:0] nxt;
			logic [CMP_W-1:0] lim;
			nxt = CMP_W'(pd_q) + CMP_W'(1);
			lim = (CMP_W'(npoint_q) > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS)
				: CMP_W'(npoint_q);
			if (nxt >= lim)
				pd_q <= '0;
			else
				pd_q <= nxt[PD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			logic             ovf;
			logic [CMP_W-1:0] nxt;
			logic [CMP_W-1:0] lim;
			ovf = 1'b0;
			for (int i = 0; i < LANES; i++) begin
				if (div_q == '0) begin
					res_q[i] <= '0;
					ovf = 1'b1;
				end else if (neg_q[i]) begin
					if (big_q[i] || quo_q[i] > SAT_NEG) begin
						res_q[i] <= SAT_NEG;
						ovf = 1'b1;
					end else begin
						res_q[i] <= OUT_W'(0) - quo_q[i];
					end
				end else begin
					if (big_q[i] || quo_q[i][31]) begin
						res_q[i] <= SAT_POS;
						ovf = 1'b1;
					end else begin
						res_q[i] <= quo_q[i];
					end
				end
			end
			nxt = CMP_W'(pd_q) + CMP_W'(1);
			lim = (CMP_W'(npoint_q) > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS)
				: CMP_W'(npoint_q);
			ovf_q  <= ovf;
			last_q <= (nxt >= lim);
		end
	end

	assign mode_u     = res_q[0];
	assign mode_v     = res_q[1];
	assign mode_w     = res_q[2];
	assign mode_p     = res_q[3];
	assign last_point = last_q;
	assign overflow   = ovf_q;

endmodule
`default_nettype wire

FILE: design/pod_spatial_mode_projection.sv
// Top level of the snapshot POD spatial mode projection block.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | coefficient, sample_u/v/w/p, last_snapshot
//  out     | out_valid/out_ready  | mode_u/v/w/p, last_point, overflow
//
// While idle, an item without last_snapshot is taken every cycle into the enabled lanes.
// An item with last_snapshot starts the divisor product, remainder setup and
// 32 steps of the restoring dividers, then the result is written to the output register.
// The next point's items are taken while that result waits; for a further last item, the
// result waits for the output register. Reset restores register defaults and clears sums.
`default_nettype none
module pod_spatial_mode_projection
	import psmp_pkg::*;
#(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [15:0]  coefficient,
	input  wire logic signed [15:0]  sample_u,
	input  wire logic signed [15:0]  sample_v,
	input  wire logic signed [15:0]  sample_w,
	input  wire logic signed [15:0]  sample_p,
	input  wire logic                last_snapshot,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [31:0]       mode_u,
	output logic signed [31:0]       mode_v,
	output logic signed [31:0]       mode_w,
	output logic signed [31:0]       mode_p,
	output logic                     last_point,
	output logic                     overflow
);

	psmp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	psmp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.last_snapshot (last_snapshot),
		.in_ready      (in_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cmd           (cmd)
	);

	psmp_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.coefficient (coefficient),
		.sample_u    (sample_u),
		.sample_v    (sample_v),
		.sample_w    (sample_w),
		.sample_p    (sample_p),
		.mode_u      (mode_u),
		.mode_v      (mode_v),
		.mode_w      (mode_w),
		.mode_p      (mode_p),
		.last_point  (last_point),
		.overflow    (overflow)
	);

endmodule
`default_nettype wire

FILE: design/psmp_chk.sv
// Port-level checker for the spatial mode projection block, with its bind.
`default_nettype none
module psmp_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_ready,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic last_snapshot,
	input wire logic out_valid,
	input wire logic out_ready
);

	// A result waiting for its taker stays presented.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped before it was taken");

	// The item that closes a point starts the division, so intake pauses.
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_snapshot |=> !in_ready)
		else $error("intake continued after a closing item");

	// A new result appears only at the end of a division.
	a_rise_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a division");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind pod_spatial_mode_projection psmp_chk u_psmp_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_ready     (cfg_ready),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.last_snapshot (last_snapshot),
	.out_valid     (out_valid),
	.out_ready     (out_ready)
);
`default_nettype wire

FILE: verif/tb_pod_spatial_mode_projection.sv
// Self-checking bench for the projection block: directed table, mode sweep, corner cases, random points.
`default_nettype none
module tb_pod_spatial_mode_projection;
	import psmp_pkg::*;

	typedef struct packed {
		logic signed [31:0] mu;
		logic signed [31:0] mv;
		logic signed [31:0] mw;
		logic signed [31:0] mp;
		logic               lastp;
		logic               ovf;
	} mode_res_t;

	typedef struct {
		logic signed [15:0] coef;
		logic signed [15:0] su, sv, sw, sp;
		logic               lsnap;
		logic               known;
		mode_res_t          res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0, in_ready;
	logic signed [15:0] coefficient = '0, sample_u = '0, sample_v = '0, sample_w = '0;
	logic signed [15:0] sample_p = '0;
	logic last_snapshot = 1'b0;
	logic out_valid, out_ready = 1'b0;
	logic signed [31:0] mode_u, mode_v, mode_w, mode_p;
	logic last_point, overflow;

	pod_spatial_mode_projection u_top (.*);

	always #2 clk = ~clk;

	// Predictor state.
	logic [2:0]  p_mode;
	logic [10:0] p_nsnap;
	logic [31:0] p_eigen;
	logic [20:0] p_npoint;
	logic [47:0] acc_u, acc_v, acc_w, acc_p;
	logic [19:0] pts_done;

	mode_res_t modes_pending[$];
	int mismatches = 0, results_seen = 0, items_sent = 0;
	int out_wait = 0;
	bit stim_done = 1'b0;

	function automatic logic [31:0] lane_quot(logic [47:0] s, logic [63:0] dv, ref logic ovf);
		logic [63:0] mag, q;
		logic neg;
		neg = s[47];
		mag = neg ? {16'd0, (~s + 48'd1)} : {16'd0, s};
		q = (mag << 9) / dv;
		if (neg) begin
			if (q > 64'h8000_0000) begin
				ovf = 1'b1;
				q = 64'h8000_0000;
			end
			return 32'(-q);
		end
		if (q > 64'h7FFF_FFFF) begin
			ovf = 1'b1;
			q = 64'h7FFF_FFFF;
		end
		return q[31:0];
	endfunction

	function automatic logic [47:0] mac48(logic [47:0] a, logic signed [15:0] c,
			logic signed [15:0] x);
		logic signed [31:0] pr;
		pr = c * x;
		return a + {{16{pr[31]}}, pr};
	endfunction

	function automatic bit project_snapshot(stim_row_t r, output mode_res_t o);
		logic [63:0] dv, lim;
		logic ov;
		logic [3:0] sel;
		sel = 4'b0000;
		case (p_mode)
			MODE_KE_UVW: sel = 4'b0111;
			MODE_P_ONLY: sel = 4'b1000;
			MODE_Q_ALL:  sel = 4'b1111;
			MODE_U:      sel = 4'b0001;
			MODE_V:      sel = 4'b0010;
			MODE_W:      sel = 4'b0100;
			default:     sel = 4'b0000;
		endcase
		if (sel[0]) acc_u = mac48(acc_u, r.coef, r.su);
		if (sel[1]) acc_v = mac48(acc_v, r.coef, r.sv);
		if (sel[2]) acc_w = mac48(acc_w, r.coef, r.sw);
		if (sel[3]) acc_p = mac48(acc_p, r.coef, r.sp);
		o = '0;
		if (!r.lsnap) return 1'b0;
		dv = 64'(p_nsnap) * 64'(p_eigen);
		ov = 1'b0;
		if (dv == 0) begin
			ov = 1'b1;
		end else begin
			o.mu = lane_quot(acc_u, dv, ov);
			o.mv = lane_quot(acc_v, dv, ov);
			o.mw = lane_quot(acc_w, dv, ov);
			o.mp = lane_quot(acc_p, dv, ov);
		end
		acc_u = '0; acc_v = '0; acc_w = '0; acc_p = '0;
		lim = (p_npoint > MAX_POINTS_DEF) ? 64'(MAX_POINTS_DEF) : 64'(p_npoint);
		o.lastp = (64'(pts_done) + 1) >= lim;
		pts_done = o.lastp ? 20'd0 : pts_done + 20'd1;
		o.ovf = ov;
		return 1'b1;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_IDX_MODE:   p_mode = val[2:0];
			CFG_IDX_NSNAP:  p_nsnap = val[10:0];
			CFG_IDX_EIGEN:  p_eigen = val;
			CFG_IDX_NPOINT: p_npoint = val[20:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_snapshot(stim_row_t r);
		mode_res_t o;
		int n;
		n = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 14));
		// Valid stays high between items that follow with no gap.
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		coefficient <= r.coef;
		sample_u <= r.su; sample_v <= r.sv; sample_w <= r.sw; sample_p <= r.sp;
		last_snapshot <= r.lsnap;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (project_snapshot(r, o)) begin
			// Typed-in rows must agree with the predictor too.
			if (r.known && o != r.res) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row disagrees with predictor: %h vs %h", r.res, o);
			end
			modes_pending.push_back(o);
		end
	endtask

	task automatic drain_idle();
		in_valid <= 1'b0;
		while (modes_pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic stim_row_t mk(logic signed [15:0] c, logic signed [15:0] u,
			logic signed [15:0] v, logic signed [15:0] w, logic signed [15:0] p,
			logic l, logic k, mode_res_t e);
		stim_row_t r;
		r.coef = c; r.su = u; r.sv = v; r.sw = w; r.sp = p;
		r.lsnap = l; r.known = k; r.res = e;
		return r;
	endfunction

	// Output side: a drawn wait per item, compare against the oldest expectation.
	always @(posedge clk) begin
		mode_res_t e, a;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				a = '{mode_u, mode_v, mode_w, mode_p, last_point, overflow};
				results_seen++;
				if (modes_pending.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", a);
				end else begin
					e = modes_pending.pop_front();
					if (a !== e) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %h got %h", e, a);
					end
				end
				out_wait = int'($urandom_range(0, 14));
			end else if (out_valid && out_wait > 0) begin
				out_wait--;
			end
			out_ready <= (out_wait == 0);
		end
	end

	stim_row_t dir_tab[$];

	initial begin
		mode_res_t z;
		logic [31:0] mv;
		int npts, ns;
		p_mode = MODE_Q_ALL; p_nsnap = 11'd1; p_eigen = 32'd65536; p_npoint = 21'd1;
		acc_u = '0; acc_v = '0; acc_w = '0; acc_p = '0; pts_done = '0;
		z = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Reset defaults: N=1, E=1.0, one point per pass.  1.0*1.0 gives 1.0 in Q16.16.
		dir_tab.push_back(mk(16'sh4000, 16'sh0100, 16'sh0200, -16'sh0100, 16'sh0000, 1, 1,
			'{32'sh8000, 32'sh10000, -32'sh8000, 0, 1, 0}));
		dir_tab.push_back(mk(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1, 0, z));
		dir_tab.push_back(mk(-16'sh8000, -16'sh8000, 16'sh7FFF, -16'sh8000, -16'sh8000, 1,
			0, z));
		dir_tab.push_back(mk(-16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, z));
		dir_tab.push_back(mk(-16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh0001, -16'sh0001, 1,
			0, z));
		dir_tab.push_back(mk(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1, 1,
			'{0, 0, 0, 0, 1, 0}));
		foreach (dir_tab[i]) send_snapshot(dir_tab[i]);
		drain_idle();
		// Every mode, including the two unused codes; the last code runs with a raw eigenvalue of 1.
		for (int m = 0; m < 8; m++) begin
			write_reg(CFG_IDX_MODE, m);
			write_reg(CFG_IDX_EIGEN, (m == 7) ? 32'd1 : 32'd65536);
			write_reg(CFG_IDX_NPOINT, 32'd3);
			for (int k = 0; k < 3; k++)
				send_snapshot(mk(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), k == 2, 0, z));
			drain_idle();
		end
		// Zero divisor from either factor, then all-ones eigenvalue and zero point count, then an all-ones point count.
		write_reg(CFG_IDX_NSNAP, 0);
		send_snapshot(mk(16'sh1234, 16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 1, 0, z));
		drain_idle();
		write_reg(CFG_IDX_NSNAP, 1024);
		write_reg(CFG_IDX_EIGEN, 0);
		send_snapshot(mk(16'sh1234, 16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 1, 0, z));
		drain_idle();
		write_reg(CFG_IDX_EIGEN, 32'hFFFF_FFFF);
		write_reg(CFG_IDX_NPOINT, 0);
		send_snapshot(mk(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1, 0, z));
		drain_idle();
		write_reg(CFG_IDX_NPOINT, 32'h001F_FFFF);
		send_snapshot(mk(16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 1, 0, z));
		drain_idle();

		// Random phases: each phase picks a configuration and streams a few points.
		while (items_sent < 1300) begin
			write_reg(CFG_IDX_MODE, $urandom_range(0, 9) == 0 ? $urandom_range(6, 7)
				: $urandom_range(0, 5));
			ns = $urandom_range(0, 9) == 0 ? 1024 : $urandom_range(1, 12);
			write_reg(CFG_IDX_NSNAP, $urandom_range(0, 19) == 0 ? 0 : ns);
			case ($urandom_range(0, 4))
				0: mv = $urandom;
				1: mv = $urandom_range(1, 255);
				2: mv = 32'hFFFF_FFFF;
				default: mv = $urandom_range(1 << 10, 1 << 20);
			endcase
			write_reg(CFG_IDX_EIGEN, mv);
			write_reg(CFG_IDX_NPOINT, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 6));
			npts = $urandom_range(1, 8);
			for (int p = 0; p < npts; p++) begin
				int nsnap;
				nsnap = $urandom_range(1, 12);
				for (int s = 0; s < nsnap; s++)
					send_snapshot(mk(16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), s == nsnap - 1, 0, z));
			end
			drain_idle();
		end
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		$display("Sent %0d snapshot items, checked %0d projected point results.",
			items_sent, results_seen);
		if (mismatches == 0 && modes_pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
design/psmp_pkg.sv
design/psmp_ctrl.sv
design/psmp_dp.sv
design/pod_spatial_mode_projection.sv
design/psmp_chk.sv
verif/tb_pod_spatial_mode_projection.sv
